FILE: rtl/u2u8_pkg.sv
package u2u8_pkg;

    localparam int ByteW = 8;
    localparam int MaxBytes = 4;
    localparam int IdxW = 2;

    typedef logic [ByteW-1:0] byte_t;
    typedef logic [IdxW-1:0] idx_t;

    localparam logic [15:0] HIGH_SURR_FIRST = 16'hD800;
    localparam logic [15:0] HIGH_SURR_LAST  = 16'hDBFF;
    localparam logic [15:0] LOW_SURR_FIRST  = 16'hDC00;
    localparam logic [15:0] LOW_SURR_LAST   = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE       = 21'h10000;
    localparam logic [15:0] ONE_BYTE_MAX    = 16'h007F;
    localparam logic [15:0] TWO_BYTE_MAX    = 16'h07FF;

    localparam logic [7:0] LEAD2 = 8'hC0;
    localparam logic [7:0] LEAD3 = 8'hE0;
    localparam logic [7:0] LEAD4 = 8'hF0;
    localparam logic [7:0] CONT  = 8'h80;

    localparam idx_t LAST_IDX_1 = 2'd0;
    localparam idx_t LAST_IDX_2 = 2'd1;
    localparam idx_t LAST_IDX_3 = 2'd2;
    localparam idx_t LAST_IDX_4 = 2'd3;

    // bytes of one code point (or one error word), sent lowest index first
    typedef struct packed {
        logic [MaxBytes-1:0][ByteW-1:0] bytes;
        idx_t                           last_idx;
        logic                           is_error;
        logic                           text_done;
    } bundle_t;

endpackage

FILE: rtl/u2u8_decode.sv
module u2u8_decode
    import u2u8_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    accept,
    input  byte_t   in_byte,
    input  logic    end_of_text,
    input  logic    byte_order_little,
    output logic    emit,
    output bundle_t bundle
);

    byte_t       held_byte_reg, held_byte_next;
    logic        have_held_reg, have_held_next;
    logic [9:0]  high_bits_reg, high_bits_next;
    logic        have_high_reg, have_high_next;
    logic        failed_reg, failed_next;

    logic [15:0] unit;
    logic [20:0] supp_cp;
    logic        produce;

    always_comb
    begin
        held_byte_next = held_byte_reg;
        have_held_next = have_held_reg;
        high_bits_next = high_bits_reg;
        have_high_next = have_high_reg;
        failed_next    = failed_reg;
        produce        = 1'b0;
        bundle         = '0;

        unit    = byte_order_little ? {in_byte, held_byte_reg} : {held_byte_reg, in_byte};
        supp_cp = {1'b0, high_bits_reg, unit[9:0]} + SUPP_BASE;

        if (!failed_reg)
        begin
            if (!have_held_reg)
            begin
                held_byte_next = in_byte;
                have_held_next = 1'b1;
                if (end_of_text)
                begin
                    failed_next = 1'b1;
                end
            end
            else
            begin
                held_byte_next = '0;
                have_held_next = 1'b0;
                if (have_high_reg)
                begin
                    if (unit inside {[LOW_SURR_FIRST:LOW_SURR_LAST]})
                    begin
                        high_bits_next = '0;
                        have_high_next = 1'b0;
                        produce        = 1'b1;
                        bundle.last_idx = LAST_IDX_4;
                        bundle.bytes[0] = LEAD4 | {5'd0, supp_cp[20:18]};
                        bundle.bytes[1] = CONT | {2'd0, supp_cp[17:12]};
                        bundle.bytes[2] = CONT | {2'd0, supp_cp[11:6]};
                        bundle.bytes[3] = CONT | {2'd0, supp_cp[5:0]};
                    end
                    else
                    begin
                        failed_next = 1'b1;
                    end
                end
                else if (unit inside {[HIGH_SURR_FIRST:HIGH_SURR_LAST]})
                begin
                    high_bits_next = unit[9:0];
                    have_high_next = 1'b1;
                end
                else if (unit inside {[LOW_SURR_FIRST:LOW_SURR_LAST]})
                begin
                    failed_next = 1'b1;
                end
                else
                begin
                    produce = 1'b1;
                    if (unit <= ONE_BYTE_MAX)
                    begin
                        bundle.last_idx = LAST_IDX_1;
                        bundle.bytes[0] = unit[7:0];
                    end
                    else if (unit <= TWO_BYTE_MAX)
                    begin
                        bundle.last_idx = LAST_IDX_2;
                        bundle.bytes[0] = LEAD2 | {3'd0, unit[10:6]};
                        bundle.bytes[1] = CONT | {2'd0, unit[5:0]};
                    end
                    else
                    begin
                        bundle.last_idx = LAST_IDX_3;
                        bundle.bytes[0] = LEAD3 | {4'd0, unit[15:12]};
                        bundle.bytes[1] = CONT | {2'd0, unit[11:6]};
                        bundle.bytes[2] = CONT | {2'd0, unit[5:0]};
                    end
                end
                if (end_of_text && have_high_next)
                begin
                    failed_next = 1'b1;
                end
            end
        end

        // error word replaces whatever the last item would have produced
        if (end_of_text && failed_next)
        begin
            bundle          = '0;
            bundle.last_idx = LAST_IDX_1;
            bundle.is_error = 1'b1;
        end
        bundle.text_done = end_of_text;

        emit = accept && ((produce && !failed_next) || (end_of_text && failed_next));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_byte_reg <= '0;
            have_held_reg <= 1'b0;
            high_bits_reg <= '0;
            have_high_reg <= 1'b0;
            failed_reg    <= 1'b0;
        end
        else if (accept)
        begin
            if (end_of_text)
            begin
                held_byte_reg <= '0;
                have_held_reg <= 1'b0;
                high_bits_reg <= '0;
                have_high_reg <= 1'b0;
                failed_reg    <= 1'b0;
            end
            else
            begin
                held_byte_reg <= held_byte_next;
                have_held_reg <= have_held_next;
                high_bits_reg <= high_bits_next;
                have_high_reg <= have_high_next;
                failed_reg    <= failed_next;
            end
        end
    end

endmodule

FILE: rtl/u2u8_serial.sv
module u2u8_serial
    import u2u8_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  bundle_t bundle_in,
    output logic    free,
    output logic    out_valid,
    input  logic    out_ready,
    output byte_t   out_byte,
    output logic    out_last,
    output logic    out_error,
    output logic    out_done
);

    bundle_t bundle_reg;
    logic    valid_reg, valid_next;
    idx_t    idx_reg, idx_next;
    logic    taken;
    logic    at_last;

    assign at_last   = (idx_reg == bundle_reg.last_idx);
    assign taken     = valid_reg && out_ready;
    assign free      = !valid_reg || (taken && at_last);

    assign out_valid = valid_reg;
    assign out_byte  = bundle_reg.bytes[idx_reg];
    assign out_last  = at_last;
    assign out_error = bundle_reg.is_error;
    assign out_done  = bundle_reg.text_done && at_last;

    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (taken)
        begin
            if (at_last)
            begin
                valid_next = 1'b0;
                idx_next   = '0;
            end
            else
            begin
                idx_next = idx_reg + idx_t'(1);
            end
        end
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bundle_reg <= bundle_in;
        end
    end

endmodule

FILE: rtl/utf16_to_utf8_transcoder_unit.sv
// UTF-16 to UTF-8 transcoder. Takes the text one byte per word on s_axis, with
// s_tlast on the final byte, and sends UTF-8 one byte per word on m_axis; m_tlast
// marks the last byte produced by an input word and m_tuser[1] the last byte of
// the text. On malformed input (lone or unpaired surrogate, odd byte count) all
// further output is withheld and the end-of-text word yields one zero byte with
// m_tuser[0] set; bytes already sent for that text must be dropped. cfg_wdata
// written with cfg_wen picks byte order (1 = little endian); the user must change
// it only while idle, which the block itself does not enforce. Flow: an input
// word is taken whenever the output register is empty or its last byte leaves in
// that cycle; a word that completes a code point loads 1 to 4 bytes into the
// output register, which drains one byte per cycle while m_tready is high. A BMP
// code point takes two input bytes and a surrogate pair four.
module utf16_to_utf8_transcoder_unit
    import u2u8_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wen,
    input  logic       cfg_wdata,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // in_byte
    input  logic       s_tlast,   // end_of_text
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_byte
    output logic       m_tlast,   // last_in_run
    output logic [1:0] m_tuser    // [1] text_done, [0] is_error
);

    logic    byte_order_little_reg;
    logic    accept;
    logic    emit;
    logic    free;
    logic    out_error;
    logic    out_done;
    bundle_t bundle;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_order_little_reg <= 1'b0;
        end
        else if (cfg_wen)
        begin
            byte_order_little_reg <= cfg_wdata;
        end
    end

    assign s_tready = free;
    assign accept   = s_tvalid && free;
    assign m_tuser  = {out_done, out_error};

    u2u8_decode u_decode (
        .clk               (clk),
        .rst_n             (rst_n),
        .accept            (accept),
        .in_byte           (s_tdata),
        .end_of_text       (s_tlast),
        .byte_order_little (byte_order_little_reg),
        .emit              (emit),
        .bundle            (bundle)
    );

    u2u8_serial u_serial (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (emit),
        .bundle_in (bundle),
        .free      (free),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_byte  (m_tdata),
        .out_last  (m_tlast),
        .out_error (out_error),
        .out_done  (out_done)
    );

endmodule

FILE: rtl/u2u8_checker.sv
module u2u8_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic [1:0] m_tuser
);

    // error word is a lone zero byte that closes the text
    a_error_word: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata == 8'd0 && m_tlast && m_tuser[1])
        else $error("error word malformed");

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tlast)
        else $error("text end not on last byte of run");

    // a multi-byte sequence is sent without gaps
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid && !m_tuser[0])
        else $error("utf-8 sequence broken off");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output word changed under stall");

endmodule

bind utf16_to_utf8_transcoder_unit u2u8_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

FILE: verif/utf16_to_utf8_transcoder_unit_tb.sv
module utf16_to_utf8_transcoder_unit_tb;
    import u2u8_pkg::*;

    localparam int ItemTarget = 400;
    localparam int CycleLimit = 400000;
    localparam int Settle = 8;
    localparam int MaxPrinted = 50;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       err;
        logic       done;
    } utf8_word_t;

    class utf8_scoreboard;
        bit         order_little;
        bit [7:0]   held;
        bit         have_held;
        bit [9:0]   high_bits;
        bit         have_high;
        bit         failed;
        utf8_word_t expected_utf8[$];
        int         mismatches;

        function void clear_text();
            held = 0;
            have_held = 0;
            high_bits = 0;
            have_high = 0;
            failed = 0;
        endfunction

        task report(string what, int got, int want);
            mismatches++;
            if (mismatches <= MaxPrinted)
                $display("mismatch on %s: got %0h, expected %0h at %0t", what, got, want, $time);
        endtask

        // accepted input byte: advance the text state and queue the utf-8 it yields
        function void note_word(bit [7:0] b, bit eot);
            bit [15:0]  unit;
            bit [20:0]  cp;
            bit [7:0]   enc [4];
            bit         emit;
            int         n;
            utf8_word_t w;
            emit = 0;
            cp = 0;
            n = 0;
            if (!failed) begin
                if (!have_held) begin
                    held = b;
                    have_held = 1;
                    if (eot)
                        failed = 1;
                end
                else begin
                    unit = order_little ? {b, held} : {held, b};
                    have_held = 0;
                    held = 0;
                    if (have_high) begin
                        if (unit >= LOW_SURR_FIRST && unit <= LOW_SURR_LAST) begin
                            cp = SUPP_BASE + {1'b0, high_bits, unit[9:0]};
                            have_high = 0;
                            high_bits = 0;
                            emit = 1;
                        end
                        else
                            failed = 1;
                    end
                    else if (unit >= HIGH_SURR_FIRST && unit <= HIGH_SURR_LAST) begin
                        high_bits = unit[9:0];
                        have_high = 1;
                    end
                    else if (unit >= LOW_SURR_FIRST && unit <= LOW_SURR_LAST)
                        failed = 1;
                    else begin
                        cp = {5'd0, unit};
                        emit = 1;
                    end
                    if (eot && have_high)
                        failed = 1;
                end
            end
            if (eot && failed) begin
                w = '{data: 8'd0, last: 1'b1, err: 1'b1, done: 1'b1};
                expected_utf8 = {expected_utf8, w};
                clear_text();
                return;
            end
            if (failed)
                return;
            if (emit) begin
                if (cp <= 21'(ONE_BYTE_MAX)) begin
                    enc[0] = cp[7:0];
                    n = 1;
                end
                else if (cp <= 21'(TWO_BYTE_MAX)) begin
                    enc[0] = LEAD2 | {3'd0, cp[10:6]};
                    enc[1] = CONT | {2'd0, cp[5:0]};
                    n = 2;
                end
                else if (cp < SUPP_BASE) begin
                    enc[0] = LEAD3 | {4'd0, cp[15:12]};
                    enc[1] = CONT | {2'd0, cp[11:6]};
                    enc[2] = CONT | {2'd0, cp[5:0]};
                    n = 3;
                end
                else begin
                    enc[0] = LEAD4 | {5'd0, cp[20:18]};
                    enc[1] = CONT | {2'd0, cp[17:12]};
                    enc[2] = CONT | {2'd0, cp[11:6]};
                    enc[3] = CONT | {2'd0, cp[5:0]};
                    n = 4;
                end
            end
            for (int i = 0; i < n; i++) begin
                w.data = enc[i];
                w.last = (i == n - 1);
                w.err = 1'b0;
                w.done = eot && (i == n - 1);
                expected_utf8 = {expected_utf8, w};
            end
            if (eot)
                clear_text();
        endfunction

        task check_word(logic [7:0] d, logic last, logic err, logic done);
            utf8_word_t want;
            if (expected_utf8.size() == 0) begin
                report("unexpected word", d, 0);
                return;
            end
            want = expected_utf8.pop_front();
            if (d !== want.data)
                report("out_byte", d, want.data);
            if (last !== want.last)
                report("last_in_run", last, want.last);
            if (err !== want.err)
                report("is_error", err, want.err);
            if (done !== want.done)
                report("text_done", done, want.done);
        endtask
    endclass

    logic       clk;
    logic       rst_n;
    logic       cfg_wen;
    logic       cfg_wdata;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic [1:0] m_tuser;

    utf8_scoreboard sb;
    logic [7:0]     text_bytes[$];
    bit             calm;
    int             items_sent;
    int             cycles;

    utf16_to_utf8_transcoder_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_wen  (cfg_wen),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("utf16_to_utf8_transcoder_unit_tb: FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_word(m_tdata, m_tlast, m_tuser[0], m_tuser[1]);
    end

    // output side back-pressure
    initial
    begin
        int stall;
        m_tready = 0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 14);
            if (stall > 0) begin
                m_tready <= 0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eot);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1;
        s_tdata <= b;
        s_tlast <= eot;
        do @(posedge clk); while (!s_tready);
        sb.note_word(b, eot);
        items_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 0;
        while (sb.expected_utf8.size() != 0)
            @(posedge clk);
        repeat (Settle) @(posedge clk);
    endtask

    task automatic send_text();
        int n;
        int hold_at;
        n = text_bytes.size();
        hold_at = ($urandom_range(0, 19) == 0) ? n / 2 : -1;
        for (int i = 0; i < n; i++) begin
            if (i == hold_at && i > 0)
                wait_drained();
            send_byte(text_bytes[i], i == n - 1);
        end
        text_bytes.delete();
    endtask

    task automatic write_order(input logic little);
        wait_drained();
        cfg_wen <= 1;
        cfg_wdata <= little;
        @(posedge clk);
        cfg_wen <= 0;
        sb.order_little = little;
    endtask

    function automatic void push_unit(logic [15:0] u);
        if (sb.order_little)
            text_bytes = {text_bytes, u[7:0], u[15:8]};
        else
            text_bytes = {text_bytes, u[15:8], u[7:0]};
    endfunction

    function automatic void push_code_point(logic [20:0] cp);
        logic [20:0] off;
        if (cp >= SUPP_BASE) begin
            off = cp - SUPP_BASE;
            push_unit(HIGH_SURR_FIRST | {6'd0, off[19:10]});
            push_unit(LOW_SURR_FIRST | {6'd0, off[9:0]});
        end
        else
            push_unit(cp[15:0]);
    endfunction

    function automatic logic [20:0] random_code_point();
        logic [20:0] cp;
        case ($urandom_range(0, 3))
            0: cp = 21'($urandom_range(0, 'h7F));
            1: cp = 21'($urandom_range('h80, 'h7FF));
            2:
            begin
                cp = 21'($urandom_range('h800, 'hF7FF));
                if (cp >= 21'(HIGH_SURR_FIRST))
                    cp = cp + 21'h800;
            end
            default: cp = 21'($urandom_range('h10000, 'h10FFFF));
        endcase
        return cp;
    endfunction

    task automatic send_random_text();
        int kind;
        int len;
        int flaw;
        int flaw_at;
        kind = $urandom_range(0, 9);
        len = $urandom_range(1, 6);
        flaw = $urandom_range(0, 3);
        flaw_at = (kind >= 7) ? $urandom_range(0, len - 1) : -1;
        for (int i = 0; i < len; i++) begin
            if (i == flaw_at && flaw == 0)
                push_unit(LOW_SURR_FIRST + 16'($urandom_range(0, 'h3FF)));
            else if (i == flaw_at && flaw == 1) begin
                push_unit(HIGH_SURR_FIRST + 16'($urandom_range(0, 'h3FF)));
                if ($urandom_range(0, 1))
                    push_unit(HIGH_SURR_FIRST + 16'($urandom_range(0, 'h3FF)));
                else
                    push_unit(16'($urandom_range(0, 'h7F)));
            end
            push_code_point(random_code_point());
        end
        if (kind >= 7 && flaw == 2)
            push_unit(HIGH_SURR_FIRST + 16'($urandom_range(0, 'h3FF)));
        if (kind >= 7 && flaw == 3)
            text_bytes = {text_bytes, 8'($urandom_range(0, 255))};
        if (kind == 9) begin
            // raw noise
            text_bytes.delete();
            len = $urandom_range(1, 8);
            for (int i = 0; i < len; i++)
                text_bytes = {text_bytes, 8'($urandom_range(0, 255))};
        end
        send_text();
    endtask

    initial
    begin
        int goal;
        sb = new();
        rst_n = 0;
        cfg_wen = 0;
        cfg_wdata = 0;
        s_tvalid = 0;
        s_tdata = 0;
        s_tlast = 0;
        calm = 0;
        items_sent = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        write_order(1'b0);

        // encoding boundaries and surrogate pair extremes
        push_unit(16'h0000);
        push_unit(ONE_BYTE_MAX);
        push_unit(ONE_BYTE_MAX + 16'd1);
        push_unit(TWO_BYTE_MAX);
        push_unit(TWO_BYTE_MAX + 16'd1);
        push_unit(16'hFFFF);
        push_unit(HIGH_SURR_FIRST);
        push_unit(LOW_SURR_FIRST);
        push_unit(HIGH_SURR_LAST);
        push_unit(LOW_SURR_LAST);
        send_text();
        // lone low surrogate, then a word after the error
        push_unit(LOW_SURR_FIRST);
        push_unit(16'h0041);
        send_text();
        // high surrogate without its low half
        push_unit(HIGH_SURR_FIRST);
        push_unit(16'h0041);
        send_text();
        // high surrogate still open at end of text
        push_unit(HIGH_SURR_LAST);
        send_text();
        // odd byte count
        text_bytes = {text_bytes, 8'h41};
        send_text();

        goal = items_sent;
        for (int phase = 0; phase < 4; phase++) begin
            write_order(phase % 2 == 0);
            calm = (phase == 2);
            goal = goal + ItemTarget / 4;
            while (items_sent < goal)
                send_random_text();
        end
        calm = 0;
        wait_drained();
        repeat (Settle) @(posedge clk);
        if (sb.mismatches == 0 && sb.expected_utf8.size() == 0)
            $display("utf16_to_utf8_transcoder_unit_tb: PASS");
        else
            $display("utf16_to_utf8_transcoder_unit_tb: FAIL");
        $finish;
    end

endmodule
